### rtl/ptpd_pkg.sv
// Shared constants, codes and types for the paletted texture pixel decoder.
package ptpd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_DIMENSION   = 4096;

  localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
  localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
  localparam int PIX_W   = 2 * DIM_W;
  localparam int CFG_IW  = 3;

  localparam logic [31:0] FORMAT_TAG   = 32'h3150_4C42;
  localparam logic [31:0] HEADER_BYTES = 32'd156;
  localparam logic [31:0] MIN_FILE     = HEADER_BYTES + 32'(4 * PALETTE_ENTRIES);
  localparam logic [31:0] PIXEL_LIMIT  = 32'(16 * 1024 * 1024);
  localparam logic [31:0] COMP_PALETTE = 32'd1;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_MAGIC     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COMP      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_WIDTH     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_HEIGHT    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MIP_OFS   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MIP_SIZE  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_FILE_SIZE = 3'd6;

  // Input commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Alpha modes
  localparam logic [1:0] MODE_PALETTE = 2'd0;
  localparam logic [1:0] MODE_PLANE   = 2'd1;
  localparam logic [1:0] MODE_NIBBLE  = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [1:0] mode;
  } hdr_status_t;

endpackage

### rtl/ptpd_if.sv
// Channel interfaces: configuration writes, input words and result words.
interface ptpd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ptpd_pkg::CFG_IW-1:0] index;
  logic [31:0]                data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface ptpd_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  entry_index;
  logic [31:0] entry_word;
  logic [7:0]  alpha_byte;
  logic        pixel_odd;
  modport source (output valid, command, entry_index, entry_word, alpha_byte, pixel_odd,
                  input ready);
  modport sink (input valid, command, entry_index, entry_word, alpha_byte, pixel_odd,
                output ready);
endinterface

interface ptpd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb;
  logic        header_error;
  logic [1:0]  alpha_mode;
  modport source (output valid, argb, header_error, alpha_mode, input ready);
  modport sink (input valid, argb, header_error, alpha_mode, output ready);
endinterface

### rtl/ptpd_palette.sv
// Palette store: one write port, one read port with registered read data.
module ptpd_palette (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ptpd_pkg::PAL_AW-1:0] waddr,
  input  logic [31:0]                 wdata,
  input  logic                        re,
  input  logic [ptpd_pkg::PAL_AW-1:0] raddr,
  output logic [31:0]                 rdata
);

  logic [31:0] mem [ptpd_pkg::PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ptpd_hdr_check.sv
// Header registers and validation, giving header status and alpha mode.
module ptpd_hdr_check (
  input  logic                  clk,
  input  logic                  rst,
  ptpd_cfg_if.sink              cfg,
  output ptpd_pkg::hdr_status_t status
);

  logic [31:0] magic_word;
  logic [31:0] compression_type;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [31:0] mip_offset;
  logic [31:0] mip_size;
  logic [31:0] file_size;

  // first stage: derived from the header words every cycle
  logic                       fixed_ok;
  logic                       dims_ok;
  logic                       bounds_ok;
  logic [ptpd_pkg::PIX_W-1:0] pixels;

  logic [32:0] mip_end;
  logic [31:0] pix_ext;
  logic [31:0] twice;
  logic [31:0] three_half;
  logic        pix_ok;
  logic        covers;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word       <= '0;
      compression_type <= 32'd1;
      image_width      <= 32'd1;
      image_height     <= 32'd1;
      mip_offset       <= '0;
      mip_size         <= '0;
      file_size        <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ptpd_pkg::REG_MAGIC:     magic_word       <= cfg.data;
        ptpd_pkg::REG_COMP:      compression_type <= cfg.data;
        ptpd_pkg::REG_WIDTH:     image_width      <= cfg.data;
        ptpd_pkg::REG_HEIGHT:    image_height     <= cfg.data;
        ptpd_pkg::REG_MIP_OFS:   mip_offset       <= cfg.data;
        ptpd_pkg::REG_MIP_SIZE:  mip_size         <= cfg.data;
        ptpd_pkg::REG_FILE_SIZE: file_size        <= cfg.data;
        default: ;
      endcase
    end
  end

  assign mip_end = {1'b0, mip_offset} + {1'b0, mip_size};

  always_ff @(posedge clk) begin
    fixed_ok  <= (file_size >= ptpd_pkg::MIN_FILE) &&
                 (magic_word == ptpd_pkg::FORMAT_TAG) &&
                 (compression_type == ptpd_pkg::COMP_PALETTE);
    dims_ok   <= (image_width != '0) && (image_height != '0) &&
                 (image_width <= 32'(ptpd_pkg::MAX_DIMENSION)) &&
                 (image_height <= 32'(ptpd_pkg::MAX_DIMENSION));
    bounds_ok <= (mip_offset < file_size) && (mip_end <= {1'b0, file_size});
    // only meaningful when dims_ok, so the low bits suffice
    pixels    <= image_width[ptpd_pkg::DIM_W-1:0] * image_height[ptpd_pkg::DIM_W-1:0];
  end

  assign pix_ext    = 32'(pixels);
  assign twice      = {pix_ext[30:0], 1'b0};
  assign three_half = pix_ext + ((pix_ext + 32'd1) >> 1);
  assign pix_ok     = pix_ext <= ptpd_pkg::PIXEL_LIMIT;
  assign covers     = mip_size >= pix_ext;

  always_comb begin
    status.ok   = fixed_ok && dims_ok && pix_ok && bounds_ok && covers;
    status.mode = ptpd_pkg::MODE_PALETTE;
    if (status.ok) begin
      if (mip_size >= twice) begin
        status.mode = ptpd_pkg::MODE_PLANE;
      end else if (mip_size >= three_half) begin
        status.mode = ptpd_pkg::MODE_NIBBLE;
      end
    end
  end

endmodule

### rtl/palette_texture_pixel_decoder.sv
// Top level: paletted texture pixel decoder, palette writes in, ARGB words out.
// A pixel word passes through stage 1 and then the result register on its way to rsp.
// Throughput: one word per cycle while rsp does not stall, limited by the single palette read port.
// Palette writes produce no result and retire in the accept cycle.
// Reset: header registers return to their defaults and the pipeline empties;
// the palette store is not cleared and holds garbage until written.
module palette_texture_pixel_decoder (
  input  logic     clk,
  input  logic     rst,
  ptpd_cfg_if.sink cfg,
  ptpd_in_if.sink  req,
  ptpd_out_if.source rsp
);

  ptpd_pkg::hdr_status_t status;

  logic        accept;
  logic        advance;
  logic        idx_ok_in;

  // stage 1: pixel fields waiting on the palette read data
  logic        s1_valid;
  logic        s1_idx_ok;
  logic [7:0]  s1_alpha;
  logic        s1_odd;
  logic [31:0] entry_rd;

  // result register
  logic        out_valid;
  logic [31:0] argb;
  logic        header_error;
  logic [1:0]  alpha_mode;

  logic [31:0] entry;
  logic [3:0]  nibble;
  logic [7:0]  alpha_sel;
  logic [31:0] argb_next;
  logic [1:0]  mode_next;

  // Header registers and validation. The check is pipelined one stage, which
  // is always settled by the time a word accepted after a write reaches stage 1.
  ptpd_hdr_check u_hdr (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .status (status)
  );

  // Stage 1 moves when the result register is empty or being drained.
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;
  assign idx_ok_in = {1'b0, req.entry_index} < 9'(ptpd_pkg::PALETTE_ENTRIES);

  // Palette writes go straight to the store, whatever the header says.
  // A pixel issues its read in the same cycle; data is registered in the store.
  ptpd_palette u_pal (
    .clk   (clk),
    .we    (accept && (req.command == ptpd_pkg::CMD_WRITE) && idx_ok_in),
    .waddr (req.entry_index[ptpd_pkg::PAL_AW-1:0]),
    .wdata (req.entry_word),
    .re    (accept && (req.command == ptpd_pkg::CMD_PIXEL)),
    .raddr (req.entry_index[ptpd_pkg::PAL_AW-1:0]),
    .rdata (entry_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= accept && (req.command == ptpd_pkg::CMD_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_ok <= idx_ok_in;
      s1_alpha  <= req.alpha_byte;
      s1_odd    <= req.pixel_odd;
    end
  end

  // Slots past the palette read as zero.
  assign entry  = s1_idx_ok ? entry_rd : '0;
  assign nibble = s1_odd ? s1_alpha[7:4] : s1_alpha[3:0];

  // Alpha select: plane byte, nibble times 17, or palette alpha with 0 -> 255.
  always_comb begin
    case (status.mode)
      ptpd_pkg::MODE_PLANE:  alpha_sel = s1_alpha;
      ptpd_pkg::MODE_NIBBLE: alpha_sel = {nibble, nibble};
      default:               alpha_sel = (entry[31:24] == 8'd0) ? 8'hFF : entry[31:24];
    endcase
  end

  // Bad header: argb 0, error set, mode 0.
  assign argb_next = status.ok ? {alpha_sel, entry[23:0]} : '0;
  assign mode_next = status.ok ? status.mode : ptpd_pkg::MODE_PALETTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      argb         <= argb_next;
      header_error <= !status.ok;
      alpha_mode   <= mode_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.argb         = argb;
  assign rsp.header_error = header_error;
  assign rsp.alpha_mode   = alpha_mode;

endmodule
